// File: hw/rtl/length_prefixed_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed packet deframer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define LPPD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lppd_pkg;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int BLEN_W     = 20;
    localparam int MAXSIZE_W  = 21;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int TDATA_W    = 64;
    localparam int TUSER_W    = 2;

    // Header layout and register limits.
    localparam logic [1:0]           HDR_LAST_IDX   = 2'd3;
    localparam logic [WORD_W-1:0]    HEADER_BYTES   = 32'd8;
    localparam logic [MAXSIZE_W-1:0] MAX_SIZE_CAP   = 21'd1048576;
    localparam logic [MAXSIZE_W-1:0] MAX_SIZE_RESET = 21'd4096;

    // Register word index of the packet size limit (paddr bit 2).
    localparam logic CFG_IDX_MAX_SIZE = 1'b0;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_LEN,
        PH_PROTO,
        PH_BODY,
        PH_HALT
    } lppd_phase_t;

    // One result from the parser to the output stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] body_byte;
        logic              has_byte;
        logic              last;
        logic [WORD_W-1:0] protocol_id;
        logic [BLEN_W-1:0] body_length;
        logic              bad_length;
    } lppd_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lppd_parser.sv
// ----------------------------------------------------------------------------
// lppd_parser
// Header and body tracking for the deframer: consumes one byte per step and
// produces at most one result combinationally from the current state and byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "length_prefixed_packet_deframer_macros.svh"

module lppd_parser
    import lppd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [BYTE_W-1:0]    data_byte,
    input  wire logic [MAXSIZE_W-1:0] size_limit,
    output lppd_result_t              result
);

    lppd_phase_t        phase_reg, phase_next;
    logic [1:0]         hdr_idx_reg, hdr_idx_next;
    logic [WORD_W-1:0]  length_reg, length_next;
    logic [WORD_W-1:0]  proto_reg, proto_next;
    logic [BLEN_W-1:0]  remaining_reg, remaining_next;

    logic [WORD_W-1:0]    byte_lane;
    logic [WORD_W-1:0]    length_full;
    logic [WORD_W-1:0]    proto_full;
    logic [MAXSIZE_W-1:0] limit;
    logic                 length_bad;
    logic                 hdr_last;
    logic [BLEN_W-1:0]    body_len;

    // Byte placed in its little-endian lane and the words it completes.
    assign byte_lane   = {{(WORD_W-BYTE_W){1'b0}}, data_byte} << {hdr_idx_reg, 3'b000};
    assign length_full = length_reg | byte_lane;
    assign proto_full  = proto_reg | byte_lane;
    assign hdr_last    = (hdr_idx_reg == HDR_LAST_IDX);

    // Length check: at least the header and below the capped register value.
    assign limit      = (size_limit > MAX_SIZE_CAP) ? MAX_SIZE_CAP : size_limit;
    assign length_bad = (length_full < HEADER_BYTES)
                     || (length_full >= {{(WORD_W-MAXSIZE_W){1'b0}}, limit});

    // Body length is the total length minus the header, modulo 2^20.
    assign body_len = length_reg[BLEN_W-1:0] - HEADER_BYTES[BLEN_W-1:0];

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (hdr_last)
                    begin
                        phase_next = length_bad ? PH_HALT : PH_PROTO;
                    end
                end
                PH_PROTO:
                begin
                    if (hdr_last)
                    begin
                        phase_next = (body_len == '0) ? PH_LEN : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (remaining_reg <= BLEN_W'(1))
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    // Datapath updates and the result of this step.
    always_comb
    begin
        hdr_idx_next   = hdr_idx_reg;
        length_next    = length_reg;
        proto_next     = proto_reg;
        remaining_next = remaining_reg;
        result         = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    length_next  = length_full;
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    if (hdr_last)
                    begin
                        if (length_bad)
                        begin
                            result.valid      = 1'b1;
                            result.bad_length = 1'b1;
                        end
                        else
                        begin
                            proto_next = '0;
                        end
                    end
                end
                PH_PROTO:
                begin
                    proto_next   = proto_full;
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    if (hdr_last)
                    begin
                        remaining_next = body_len;
                        if (body_len == '0)
                        begin
                            result.valid       = 1'b1;
                            result.last        = 1'b1;
                            result.protocol_id = proto_full;
                            length_next        = '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    result.valid       = 1'b1;
                    result.body_byte   = data_byte;
                    result.has_byte    = 1'b1;
                    result.last        = (remaining_reg == BLEN_W'(1));
                    result.protocol_id = proto_reg;
                    result.body_length = body_len;
                    if (remaining_reg <= BLEN_W'(1))
                    begin
                        remaining_next = '0;
                        length_next    = '0;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - BLEN_W'(1);
                    end
                end
                PH_HALT:
                begin
                    result = '0;
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            hdr_idx_reg   <= '0;
            length_reg    <= '0;
            proto_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            length_reg    <= length_next;
            proto_reg     <= proto_next;
            remaining_reg <= remaining_next;
        end
    end

    // Checks on the parser state.
    `LPPD_ASSERT_NEXT(a_halt_sticky, phase_reg == PH_HALT, phase_reg == PH_HALT, "halt state left before reset")
    `LPPD_ASSERT_NEXT(a_bad_halts, step && result.bad_length, phase_reg == PH_HALT, "error result without halt")
    `LPPD_ASSERT_IMP(a_body_nonzero, phase_reg == PH_BODY, remaining_reg != '0, "body phase with no bytes remaining")
    `LPPD_ASSERT_IMP(a_body_emits, step && phase_reg == PH_BODY, result.valid && result.has_byte, "body byte without a result")
    `LPPD_ASSERT_IMP(a_bad_at_len, result.bad_length, phase_reg == PH_LEN && hdr_last, "error result outside the length word")

endmodule

`default_nettype wire

// File: hw/rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream into length-prefixed packets and emits body bytes
// tagged with the protocol word and body length, or a result for an empty body or a bad length.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: data_byte[7:0]
// m_axis    out  tdata: body_byte[7:0], protocol_id[39:8], body_length[59:40];
//                tuser: has_byte[0], bad_length[1]; tlast: last
// APB       in   word 0 (paddr 0): size_limit[20:0]
//
// One byte per cycle while the output is not stalled; a byte is registered in the input
// register and its result, if any, in the output register.
// The rate is set by the parser update in lppd_parser, which handles one byte per step.
// Reset is asynchronous and active low; it returns the parser to the length
// word and the size limit to 4096. A stalled output holds its transaction
// and backpressure reaches s_axis_tready once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer
    import lppd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input byte stream; tdata: data_byte[7:0].
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,
    // Results; tdata: body_byte, protocol_id, body_length, zero pad.
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // tuser: has_byte, bad_length.
    output logic [TUSER_W-1:0]      m_axis_tuser,
    output logic                    m_axis_tlast,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]    in_byte_reg, in_byte_next;
    logic                 out_valid_reg, out_valid_next;
    lppd_result_t         out_reg, out_next;
    logic [MAXSIZE_W-1:0] max_size_reg, max_size_next;

    logic         s_xfer;
    logic         advance;
    logic         cfg_write;
    lppd_result_t result;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MAX_SIZE);
    assign max_size_next = cfg_write ? pwdata[MAXSIZE_W-1:0] : max_size_reg;
    assign prdata = (paddr[2] == CFG_IDX_MAX_SIZE)
                  ? {{(PDATA_W-MAXSIZE_W){1'b0}}, max_size_reg} : '0;

    // Input register: a byte moves on when the output register can take its result.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    lppd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .size_limit (max_size_reg),
        .result     (result)
    );

    // Output register: loads a new result, else drains on the output transaction.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance && result.valid)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-BYTE_W-WORD_W-BLEN_W){1'b0}},
                            out_reg.body_length, out_reg.protocol_id, out_reg.body_byte};
    assign m_axis_tuser  = {out_reg.bad_length, out_reg.has_byte};
    assign m_axis_tlast  = out_reg.last;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_size_reg  <= MAX_SIZE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            max_size_reg  <= max_size_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire
